// ===== src/sha256_pair_round57_match_top_assert.svh =====
// Assertion macros used by the port-level checker of the pair-round matcher.
`ifndef SHA256_PAIR_ROUND57_MATCH_TOP_ASSERT_SVH
`define SHA256_PAIR_ROUND57_MATCH_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/spm_pkg.sv =====
// Shared types, constants and tables of the pair-round matcher.
package spm_pkg;

  localparam int RoundCount = 57;
  localparam int DiffWord   = 9;
  localparam int CfgIdxW    = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FILL_WORD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DIFF_BIT  = 2'd1;

  localparam logic [31:0] FILL_RESET = 32'hFFFF_FFFF;
  localparam logic [4:0]  DIFF_RESET = 5'd7;

  // Round constants
  localparam logic [31:0] K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Initial hash value, a through h
  localparam logic [31:0] IV_TABLE [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Working state of one message: hv[0] is a ... hv[7] is h;
  // win[0] is the schedule word of the current round, win[15] the newest.
  typedef struct packed {
    logic [7:0][31:0]  hv;
    logic [15:0][31:0] win;
  } spm_lane_t;

  // One finished item
  typedef struct packed {
    logic [31:0] cand;
    logic [31:0] a_first;
    logic [31:0] a_second;
    logic        eligible;
  } spm_res_t;

endpackage

// ===== src/sha256_pair_round57_match_top.sv =====
// Top level of the reduced-round SHA-256 pair matcher.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  cfg     | in        | cfg_valid_i/ready_o   | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/in_ready_o | candidate_word_i
//  out     | out       | out_valid_o/ready_i   | candidate_echo_o, a_first_o, a_second_o,
//          |           |                       | eligible_o
//
// One item per cycle while the skid entry is free; one round cell per stage
// followed by the output register.
// A stalled output item parks in one skid entry; the round chain freezes only
// when that entry is full, and in_ready_o drops for as long.
// Reset clears the item valids and sets fill_word and diff_bit to their defaults.
module sha256_pair_round57_match_top import spm_pkg::*; #(
  parameter int ROUND_COUNT = RoundCount
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        candidate_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        candidate_echo_o,
  output logic [31:0]        a_first_o,
  output logic [31:0]        a_second_o,
  output logic               eligible_o
);

  logic [31:0] fill_q;
  logic [4:0]  diff_q;
  logic [31:0] delta;
  logic        adv;

  logic        st_valid [ROUND_COUNT+1];
  logic [31:0] st_cand  [ROUND_COUNT+1];
  spm_lane_t   st_first [ROUND_COUNT+1];
  spm_lane_t   st_second[ROUND_COUNT+1];

  spm_res_t    last_res;
  spm_res_t    out_res;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= FILL_RESET;
      diff_q <= DIFF_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FILL_WORD: fill_q <= cfg_data_i;
        CFG_DIFF_BIT:  diff_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Build both messages at the head of the chain
  assign delta = 32'd1 << diff_q;

  always_comb begin
    st_valid[0] = in_valid_i && in_ready_o;
    st_cand[0]  = candidate_word_i;
    for (int j = 0; j < 8; j++) begin
      st_first[0].hv[j]  = IV_TABLE[j];
      st_second[0].hv[j] = IV_TABLE[j];
    end
    for (int j = 0; j < 16; j++) begin
      st_first[0].win[j]  = fill_q;
      st_second[0].win[j] = fill_q;
    end
    st_first[0].win[0]         = candidate_word_i;
    st_second[0].win[0]        = candidate_word_i ^ delta;
    st_second[0].win[DiffWord] = fill_q ^ delta;
  end

  // Round cells
  for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
    spm_cell #(
      .RoundK(K_TABLE[i])
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (st_valid[i]),
      .cand_i  (st_cand[i]),
      .first_i (st_first[i]),
      .second_i(st_second[i]),
      .valid_o (st_valid[i+1]),
      .cand_o  (st_cand[i+1]),
      .first_o (st_first[i+1]),
      .second_o(st_second[i+1])
    );
  end

  // Result of the last cell
  always_comb begin
    last_res.cand     = st_cand[ROUND_COUNT];
    last_res.a_first  = st_first[ROUND_COUNT].hv[0];
    last_res.a_second = st_second[ROUND_COUNT].hv[0];
    last_res.eligible = (st_first[ROUND_COUNT].hv[0] == st_second[ROUND_COUNT].hv[0]);
  end

  spm_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .last_valid_i(st_valid[ROUND_COUNT]),
    .last_res_i  (last_res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res),
    .room_o      (adv)
  );

  assign in_ready_o       = adv;
  assign candidate_echo_o = out_res.cand;
  assign a_first_o        = out_res.a_first;
  assign a_second_o       = out_res.a_second;
  assign eligible_o       = out_res.eligible;

endmodule

// ===== src/spm_cell.sv =====
// One round cell: a SHA-256 round for both messages plus one schedule step.
module spm_cell import spm_pkg::*; #(
  parameter logic [31:0] RoundK = 32'h0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [31:0] cand_i,
  input  spm_lane_t   first_i,
  input  spm_lane_t   second_i,
  output logic        valid_o,
  output logic [31:0] cand_o,
  output spm_lane_t   first_o,
  output spm_lane_t   second_o
);

  logic        valid_q;
  logic [31:0] cand_q;
  spm_lane_t   first_q, first_d;
  spm_lane_t   second_q, second_d;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // Round on a..h with win[0]; window shifts down and gains W[i+16]
  function automatic spm_lane_t lane_step(input spm_lane_t s, input logic [31:0] k);
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;
    spm_lane_t   r;
    ch  = (s.hv[4] & s.hv[5]) ^ (~s.hv[4] & s.hv[6]);
    maj = (s.hv[0] & s.hv[1]) ^ (s.hv[0] & s.hv[2]) ^ (s.hv[1] & s.hv[2]);
    t1  = s.hv[7] + big_s1(s.hv[4]) + ch + k + s.win[0];
    t2  = big_s0(s.hv[0]) + maj;
    r.hv[0] = t1 + t2;
    r.hv[1] = s.hv[0];
    r.hv[2] = s.hv[1];
    r.hv[3] = s.hv[2];
    r.hv[4] = s.hv[3] + t1;
    r.hv[5] = s.hv[4];
    r.hv[6] = s.hv[5];
    r.hv[7] = s.hv[6];
    for (int j = 0; j < 15; j++) begin
      r.win[j] = s.win[j+1];
    end
    r.win[15] = small_s1(s.win[14]) + s.win[9] + small_s0(s.win[1]) + s.win[0];
    return r;
  endfunction

  always_comb begin
    first_d  = lane_step(first_i, RoundK);
    second_d = lane_step(second_i, RoundK);
  end

  // Item valid moves with the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cand_q   <= cand_i;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  assign valid_o  = valid_q;
  assign cand_o   = cand_q;
  assign first_o  = first_q;
  assign second_o = second_q;

endmodule

// ===== src/spm_outbuf.sv =====
// Output register with one skid entry behind the round chain.
module spm_outbuf import spm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     last_valid_i,
  input  spm_res_t last_res_i,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output spm_res_t out_res_o,
  output logic     room_o
);

  logic     out_v_q, out_v_d;
  spm_res_t out_q, out_d;
  logic     sk_v_q, sk_v_d;
  spm_res_t sk_q, sk_d;
  logic     arrive;
  logic     take;

  // Chain moves only while the skid entry is free
  assign room_o = !sk_v_q;
  assign arrive = room_o && last_valid_i;
  assign take   = out_v_q && out_ready_i;

  always_comb begin
    out_v_d = out_v_q;
    out_d   = out_q;
    sk_v_d  = sk_v_q;
    sk_d    = sk_q;
    if (take) begin
      if (sk_v_q) begin
        out_d  = sk_q;
        sk_v_d = 1'b0;
      end else if (arrive) begin
        out_d = last_res_i;
      end else begin
        out_v_d = 1'b0;
      end
    end else if (!out_v_q) begin
      if (arrive) begin
        out_v_d = 1'b1;
        out_d   = last_res_i;
      end
    end else if (arrive) begin
      // Output stalled: park the arriving item
      sk_v_d = 1'b1;
      sk_d   = last_res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      sk_v_q  <= sk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sk_q  <= sk_d;
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

endmodule

// ===== src/spm_checker.sv =====
// Port-level checker for the pair matcher, bound to the top level.
`include "sha256_pair_round57_match_top_assert.svh"

module spm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] candidate_echo_o,
  input logic [31:0] a_first_o,
  input logic [31:0] a_second_o,
  input logic        eligible_o
);

  // A stalled result stays offered
  `SPM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "out item dropped")

  // A stalled result keeps its candidate echo and both a values
  `SPM_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i,
                   $stable(candidate_echo_o) && $stable(a_first_o) && $stable(a_second_o),
                   "out payload moved")

  // Flag agrees with the two a registers
  `SPM_ASSERT_NOW(a_flag_match, out_valid_o,
                  eligible_o == (a_first_o == a_second_o), "eligible flag wrong")

  // Input backpressure only while a result waits at the output
  `SPM_ASSERT_NOW(a_stall_cause, !in_ready_o, out_valid_o, "input stalled with empty output")

endmodule

bind sha256_pair_round57_match_top spm_checker u_spm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .candidate_echo_o(candidate_echo_o),
  .a_first_o       (a_first_o),
  .a_second_o      (a_second_o),
  .eligible_o      (eligible_o)
);

// ===== tb/sha256_pair_round57_match_checker.sv =====
// Watches the matcher's channels, predicts each result and compares it field by field.
module sha256_pair_round57_match_checker import spm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [31:0]        candidate_word_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [31:0]        candidate_echo_i,
  input  logic [31:0]        a_first_i,
  input  logic [31:0]        a_second_i,
  input  logic               eligible_i,
  output int unsigned        mismatch_count_o,
  output int unsigned        results_owed_o
);

  localparam int          ROUNDS        = 57;
  localparam int          DIFF_WORD_IDX = 9;
  localparam logic [31:0] FILL_AT_RESET = 32'hFFFF_FFFF;
  localparam logic [4:0]  DIFF_AT_RESET = 5'd7;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [31:0] cand;
    logic [31:0] a_first;
    logic [31:0] a_second;
    logic        eligible;
  } pair_result_t;

  // Local copy of the two registers
  logic [31:0]  fill_word_q = FILL_AT_RESET;
  logic [4:0]   diff_bit_q  = DIFF_AT_RESET;

  pair_result_t owed_results [$];
  pair_result_t oldest;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Reduced compression from the standard IV, no feed-forward; returns a
  function automatic logic [31:0] a_after_rounds(input logic [15:0][31:0] msg);
    logic [15:0][31:0] w;
    logic [31:0]       a, b, c, d, e, f, g, h;
    logic [31:0]       wi, w_m2, w_m15, t1, t2;
    int                r;
    w = msg;
    a = START_HASH[0]; b = START_HASH[1]; c = START_HASH[2]; d = START_HASH[3];
    e = START_HASH[4]; f = START_HASH[5]; g = START_HASH[6]; h = START_HASH[7];
    for (r = 0; r < ROUNDS; r++) begin
      if (r < 16) begin
        wi = w[r];
      end else begin
        // rolling 16-word schedule window
        w_m2  = w[(r - 2) & 15];
        w_m15 = w[(r - 15) & 15];
        wi = (rotr(w_m2, 17) ^ rotr(w_m2, 19) ^ (w_m2 >> 10)) + w[(r - 7) & 15]
           + (rotr(w_m15, 7) ^ rotr(w_m15, 18) ^ (w_m15 >> 3)) + w[r & 15];
        w[r & 15] = wi;
      end
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_K[r & 63] + wi;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    return a;
  endfunction

  // Build both messages for one candidate and compare their a registers
  function automatic pair_result_t predict_pair(input logic [31:0] cand);
    logic [31:0]       delta;
    logic [15:0][31:0] msg_one, msg_two;
    pair_result_t      res;
    delta   = 32'd1 << diff_bit_q;
    msg_one = {16{fill_word_q}};
    msg_one[0] = cand;
    msg_two = msg_one;
    msg_two[0] = cand ^ delta;
    msg_two[DIFF_WORD_IDX] = fill_word_q ^ delta;
    res.cand     = cand;
    res.a_first  = a_after_rounds(msg_one);
    res.a_second = a_after_rounds(msg_two);
    res.eligible = (res.a_first == res.a_second);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $time, msg);
    mismatch_count_o++;
  endtask

  // Compare accepted results, queue predictions, track register writes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_word_q = FILL_AT_RESET;
      diff_bit_q  = DIFF_AT_RESET;
      owed_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result for candidate %h with no item waiting",
                                    candidate_echo_i));
        end else begin
          oldest = owed_results.pop_front();
          if (candidate_echo_i !== oldest.cand)
            report_mismatch($sformatf("candidate_echo: got %h, want %h",
                                      candidate_echo_i, oldest.cand));
          if (a_first_i !== oldest.a_first)
            report_mismatch($sformatf("a_first for candidate %h: got %h, want %h",
                                      oldest.cand, a_first_i, oldest.a_first));
          if (a_second_i !== oldest.a_second)
            report_mismatch($sformatf("a_second for candidate %h: got %h, want %h",
                                      oldest.cand, a_second_i, oldest.a_second));
          if (eligible_i !== oldest.eligible)
            report_mismatch($sformatf("eligible for candidate %h: got %b, want %b",
                                      oldest.cand, eligible_i, oldest.eligible));
        end
      end
      if (in_valid_i && in_ready_i)
        owed_results.push_back(predict_pair(candidate_word_i));
      // indexes past the register list are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_FILL_WORD)
          fill_word_q = cfg_data_i;
        else if (cfg_index_i == CFG_DIFF_BIT)
          diff_bit_q = cfg_data_i[4:0];
      end
    end
    results_owed_o = owed_results.size();
  end

endmodule

// ===== tb/sha256_pair_round57_match_top_test.sv =====
// Stimulus, idling, watchdog and verdict for the pair-round matcher.
module sha256_pair_round57_match_top_test import spm_pkg::*;;

  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_SLACK     = 80;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 230;

  // Indexes past the register list; writes to them must be ignored
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [31:0]        candidate_word_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [31:0]        candidate_echo_o;
  logic [31:0]        a_first_o;
  logic [31:0]        a_second_o;
  logic               eligible_o;

  int unsigned mismatch_count;
  int unsigned results_owed;
  int unsigned stuck_cycles;
  bit          steady;

  sha256_pair_round57_match_top dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .candidate_word_i,
    .out_valid_o, .out_ready_i, .candidate_echo_o, .a_first_o, .a_second_o, .eligible_o
  );

  sha256_pair_round57_match_checker pair_check (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .candidate_word_i,
    .out_valid_i(out_valid_o), .out_ready_i, .candidate_echo_i(candidate_echo_o),
    .a_first_i(a_first_o), .a_second_i(a_second_o), .eligible_i(eligible_o),
    .mismatch_count_o(mismatch_count), .results_owed_o(results_owed)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // One candidate; valid stays high afterwards so back-to-back items need no dip
  task automatic send_candidate(input logic [31:0] cand);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    candidate_word_i = cand;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Let the pipe drain, then rewrite both registers
  task automatic reconfigure(input logic [31:0] fill, input logic [31:0] diff_data,
                             input bit poke_spare);
    in_valid_i = 1'b0;
    while (results_owed != 0) @(negedge clk_i);
    if (poke_spare) write_reg(CFG_SPARE_LO, ~fill);
    write_reg(CFG_FILL_WORD, fill);
    write_reg(CFG_DIFF_BIT, diff_data);
    if (poke_spare) write_reg(CFG_SPARE_HI, $urandom);
    cfg_valid_i = 1'b0;
  endtask

  // Output side back-pressure
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready_i = 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk_i);
      stall = steady ? 0 : pick_gap();
      if (stall != 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  // Watchdog: cycles in which no channel moves an item
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STALL_LIMIT) begin
        $display("sha256_pair_round57_match_top_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] fill_sel;
    logic [31:0] diff_data;
    logic [31:0] cand;
    int unsigned pick;
    rst_ni           = 1'b0;
    steady           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = CFG_FILL_WORD;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    candidate_word_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Register values left by reset
    send_candidate(32'h0000_0000);
    send_candidate(32'hFFFF_FFFF);
    send_candidate(32'hFFFF_FF7F);
    send_candidate(32'hAAAA_AAAA);
    send_candidate(32'h5555_5555);

    // All-zero fill, difference in the lowest bit
    reconfigure(32'h0000_0000, 32'd0, 1'b0);
    send_candidate(32'h0000_0000);
    send_candidate(32'h0000_0001);
    send_candidate(32'hFFFF_FFFF);
    send_candidate(32'h8000_0000);

    // All-ones fill, top bit, plus writes past the register list
    reconfigure(32'hFFFF_FFFF, 32'd31, 1'b1);
    send_candidate(32'h7FFF_FFFF);
    send_candidate(32'h8000_0000);
    send_candidate(32'h0000_0000);

    // Difference data wider than five bits keeps only its low bits
    reconfigure(32'h8000_0001, 32'hFFFF_FFE5, 1'b0);
    send_candidate(32'h8000_0001);
    send_candidate(32'h8000_0021);
    send_candidate($urandom);

    // Random phases, each with its own register setting
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick = $urandom_range(0, 5);
      fill_sel  = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
      pick = $urandom_range(0, 5);
      diff_data = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd31 : $urandom;
      steady = 1'b0;
      reconfigure(fill_sel, diff_data, $urandom_range(0, 3) == 0);
      steady = (phase % 4 == 1);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 15);
        case (pick)
          0: cand = 32'h0000_0000;
          1: cand = 32'hFFFF_FFFF;
          2: cand = fill_sel;
          3: cand = fill_sel ^ (32'd1 << diff_data[4:0]);
          4: cand = 32'd1 << $urandom_range(0, 31);
          default: cand = $urandom;
        endcase
        send_candidate(cand);
      end
    end

    // Drain, then allow for anything arriving late
    steady     = 1'b0;
    in_valid_i = 1'b0;
    while (results_owed != 0) @(negedge clk_i);
    repeat (DRAIN_SLACK) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("sha256_pair_round57_match_top_test: PASS");
    end else begin
      $display("sha256_pair_round57_match_top_test: FAIL");
    end
    $finish;
  end

endmodule
